// ----- hw/rtl/psg_pkg.sv -----
// Shared types, constants and the gain table of the sound generator.
// No dependencies; compile first.
`default_nettype none
package psg_pkg;

  // Counter and accumulator width: counters saturate at the 19-bit minimum
  localparam int CNT_W = 19;
  localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int TDEC_W  = 12;
  localparam int NDEC_W  = 13;
  localparam logic REG_TONE_DEC  = 1'b0;
  localparam logic REG_NOISE_DEC = 1'b1;
  localparam logic [TDEC_W-1:0] TDEC_RST = 12'd298;
  localparam logic [NDEC_W-1:0] NDEC_RST = 13'd596;

  // Input word kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Latch field code for noise control
  localparam logic [2:0] LF_NOISE_CTL = 3'd6;

  // Channel indexes
  localparam logic [1:0] CH_NOISE = 2'd0;
  localparam logic [1:0] CH_LAST  = 2'd3;
  localparam logic [1:0] CH_TONE1 = 2'd1;

  // Noise rate code that follows tone 1
  localparam logic [1:0] RATE_TONE1 = 2'b11;

  // Reset and reload values
  localparam logic [15:0] PERIOD_RST    = 16'hFFC0;
  localparam logic [15:0] NSHIFT_SEED   = 16'h4000;
  localparam logic [15:0] NOISE_BASE    = 16'h0400;
  localparam logic [15:0] FLAT_PERIOD   = 16'd256;
  localparam logic [3:0]  NCTL_RST      = 4'd3;
  localparam logic [3:0]  ATT_TONE_RST  = 4'd8;
  localparam logic [3:0]  ATT_NOISE_RST = 4'd0;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MIX  = 5'b00010,
    ST_DEC  = 5'b00100,
    ST_RELD = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    OP_MIX  = 2'd0,
    OP_DEC  = 2'd1,
    OP_RELD = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0] ch;
    op_t        op;
    logic       idle;
    logic       acc_en;
    logic       cnt_wr;
    logic       step;
    logic       out_load;
  } ctrl_t;

  typedef struct packed {
    logic res_neg;
    logic per_nz;
    logic out_free;
  } stat_t;

  function automatic logic [10:0] gain_of(input logic [3:0] lvl);
    logic [10:0] g;
    unique case (lvl)
      4'd0:    g = 11'd0;
      4'd1:    g = 11'd76;
      4'd2:    g = 11'd95;
      4'd3:    g = 11'd120;
      4'd4:    g = 11'd151;
      4'd5:    g = 11'd191;
      4'd6:    g = 11'd240;
      4'd7:    g = 11'd302;
      4'd8:    g = 11'd380;
      4'd9:    g = 11'd479;
      4'd10:   g = 11'd602;
      4'd11:   g = 11'd758;
      4'd12:   g = 11'd955;
      4'd13:   g = 11'd1202;
      4'd14:   g = 11'd1514;
      default: g = 11'd1905;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/psg_in_if.sv -----
// Input channel: register write bytes and sample ticks.
// No dependencies.
`default_nettype none
interface psg_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data;

  modport source (output valid, output kind, output data, input ready);
  modport sink   (input valid, input kind, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/psg_out_if.sv -----
// Result channel: one signed mixed sample per tick.
// No dependencies.
`default_nettype none
interface psg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/psg_three_tone_noise_generator.sv -----
// Top level of the three-tone, one-noise sound generator: register file,
// write-byte decode, channel datapath, APB port and result register.
// Depends on psg_pkg, psg_in_if, psg_out_if, psg_sat_add and psg_seq.
//
//  Channel  Dir  Handshake           Word
//  in_ch    in   valid/ready         kind (0 write byte, 1 tick), data[7:0]
//  out_ch   out  valid/ready         sample[15:0] signed, one per tick
//  APB      in   psel/penable/pwrite paddr[2] picks tone/noise decrement
//
// A write byte is taken whenever the block is idle and updates the registers at once.
// A tick runs each channel through a mix step and a decrement step, plus one
// reload step per counter reload through the single shared adder, then loads
// the output register; in_ch.ready is low meanwhile.
// The result sits in an output register, so a new word is accepted while it
// waits; a tick that finishes before the old result is taken holds in place.
// Synchronous reset (rst_n low) loads all but sum_r, out_sample_r to power-up.
`default_nettype none
module psg_three_tone_noise_generator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  psg_in_if.sink                           in_ch,
  psg_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [psg_pkg::PADDR_W-1:0] paddr,
  input  wire logic [psg_pkg::PDATA_W-1:0] pwdata,
  output logic      [psg_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);

  localparam int W = psg_pkg::CNT_W;

  // ---------------------------------------------------------------- config
  logic [psg_pkg::TDEC_W-1:0] tone_dec_r;
  logic [psg_pkg::NDEC_W-1:0] noise_dec_r;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_dec_r  <= psg_pkg::TDEC_RST;
      noise_dec_r <= psg_pkg::NDEC_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == psg_pkg::REG_TONE_DEC) begin
        tone_dec_r <= pwdata[psg_pkg::TDEC_W-1:0];
      end else begin
        noise_dec_r <= pwdata[psg_pkg::NDEC_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == psg_pkg::REG_NOISE_DEC) begin
      prdata = {{(psg_pkg::PDATA_W-psg_pkg::NDEC_W){1'b0}}, noise_dec_r};
    end else begin
      prdata = {{(psg_pkg::PDATA_W-psg_pkg::TDEC_W){1'b0}}, tone_dec_r};
    end
  end

  // ---------------------------------------------------------------- state
  // Channel 0 is noise, 1..3 are tones.
  logic                tone_pos_r [1:3];   // phase: high means positive
  logic [15:0]         period_r   [0:3];
  logic signed [W-1:0] cnt_r      [0:3];
  logic [3:0]          freq_lo_r  [1:3];
  logic [5:0]          freq_hi_r  [1:3];
  logic [3:0]          atten_r    [0:3];
  logic [15:0]         nshift_r;
  logic [3:0]          nctl_r;
  logic [1:0]          last_tone_r;
  logic [2:0]          last_field_r;
  logic signed [W-1:0] sum_r;
  logic                out_valid_r;
  logic [15:0]         out_sample_r;

  psg_pkg::ctrl_t ctrl;
  psg_pkg::stat_t stat;

  // ---------------------------------------------------------------- input
  logic       acc, wr_en, tick;
  logic [7:0] byte_d;
  logic       latch;
  logic [2:0] fld;
  logic [1:0] fld_t;       // tone or level slot a latch byte points to
  logic [1:0] hi_t;        // safe index for the last latched tone
  logic       nc_wr, at_wr, fl_wr, hi_wr;
  logic [15:0] per_lo, per_hi, per_nc;

  assign in_ch.ready = ctrl.idle;
  assign acc    = in_ch.valid & in_ch.ready;
  assign wr_en  = acc & (in_ch.kind == psg_pkg::KIND_WRITE);
  assign tick   = acc & (in_ch.kind == psg_pkg::KIND_TICK);
  assign byte_d = in_ch.data;
  assign latch  = byte_d[7];
  assign fld    = byte_d[6:4];
  assign fld_t  = ~fld[2:1];
  assign hi_t   = (last_tone_r == psg_pkg::CH_NOISE) ? psg_pkg::CH_TONE1 : last_tone_r;

  always_comb begin
    nc_wr = wr_en & ((latch & (fld == psg_pkg::LF_NOISE_CTL)) |
                     (~latch & (last_field_r == psg_pkg::LF_NOISE_CTL)));
    at_wr = wr_en & latch & fld[0];
    fl_wr = wr_en & latch & ~fld[0] & (fld != psg_pkg::LF_NOISE_CTL);
    hi_wr = wr_en & ~latch & (last_field_r != psg_pkg::LF_NOISE_CTL);
  end

  // Latch byte: new low nibble; data byte: new high six bits.
  // fld_t is never 0 when fl_wr is set; guard the index anyway.
  always_comb begin
    if (fld_t == psg_pkg::CH_NOISE) begin
      per_lo = '0;
    end else begin
      per_lo = {freq_hi_r[fld_t], byte_d[3:0], 6'b0};
    end
    per_hi = {byte_d[5:0], freq_lo_r[hi_t], 6'b0};
    if (byte_d[1:0] == psg_pkg::RATE_TONE1) begin
      per_nc = period_r[1];
    end else begin
      per_nc = psg_pkg::NOISE_BASE << byte_d[1:0];
    end
  end

  // ---------------------------------------------------------------- datapath
  logic [1:0]          ch;
  logic [1:0]          tch;      // tone index, forced into range for noise
  logic [10:0]         gain;
  logic signed [W-1:0] contrib, dec_b, rel_b, op_a, op_b, res;
  logic [15:0]         nshift_step;
  logic                fb;

  assign ch   = ctrl.ch;
  assign tch  = (ch == psg_pkg::CH_NOISE) ? psg_pkg::CH_TONE1 : ch;
  assign gain = psg_pkg::gain_of(atten_r[ch]);

  always_comb begin
    // Contribution taken before the channel's own counter work
    if (ch == psg_pkg::CH_NOISE) begin
      contrib = nshift_r[0] ? '0 : {{(W-12){1'b0}}, gain, 1'b0};
    end else if ((period_r[ch] > psg_pkg::FLAT_PERIOD) && !tone_pos_r[tch]) begin
      contrib = -$signed({{(W-11){1'b0}}, gain});
    end else begin
      contrib = {{(W-11){1'b0}}, gain};
    end
    if (ch == psg_pkg::CH_NOISE) begin
      dec_b = -$signed({{(W-psg_pkg::NDEC_W){1'b0}}, noise_dec_r});
      rel_b = {{(W-17){1'b0}}, period_r[ch], 1'b0};
    end else begin
      dec_b = -$signed({{(W-psg_pkg::TDEC_W){1'b0}}, tone_dec_r});
      rel_b = {{(W-16){1'b0}}, period_r[ch]};
    end
    unique case (ctrl.op)
      psg_pkg::OP_MIX: begin
        op_a = sum_r;
        op_b = contrib;
      end
      psg_pkg::OP_DEC: begin
        op_a = cnt_r[ch];
        op_b = dec_b;
      end
      psg_pkg::OP_RELD: begin
        op_a = cnt_r[ch];
        op_b = rel_b;
      end
      default: begin
        op_a = sum_r;
        op_b = contrib;
      end
    endcase
  end

  psg_sat_add u_add (
    .a   (op_a),
    .b   (op_b),
    .res (res)
  );

  // Periodic mode rotates bit 0 in; white mode feeds bit0 ^ bit1.
  // The feedback lands in bit 14 together with the old bit 15; bit 15 clears.
  assign fb          = nctl_r[2] ? (nshift_r[0] ^ nshift_r[1]) : nshift_r[0];
  assign nshift_step = {1'b0, nshift_r[15] | fb, nshift_r[14:1]};

  assign stat.res_neg  = res[W-1];
  assign stat.per_nz   = (period_r[ch] != '0);
  assign stat.out_free = ~out_valid_r | out_ch.ready;

  psg_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tick),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // ---------------------------------------------------------------- updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        period_r[i] <= psg_pkg::PERIOD_RST;
        cnt_r[i]    <= '0;
        atten_r[i]  <= psg_pkg::ATT_TONE_RST;
      end
      atten_r[0] <= psg_pkg::ATT_NOISE_RST;
      for (int i = 1; i < 4; i++) begin
        tone_pos_r[i] <= 1'b1;
        freq_lo_r[i]  <= '0;
        freq_hi_r[i]  <= '0;
      end
      nshift_r     <= psg_pkg::NSHIFT_SEED;
      nctl_r       <= psg_pkg::NCTL_RST;
      last_tone_r  <= psg_pkg::CH_NOISE;
      last_field_r <= '0;
    end else begin
      // tick work: counters, phases, noise shifter
      if (ctrl.cnt_wr) begin
        cnt_r[ch] <= res;
      end
      if (ctrl.step) begin
        if (ch == psg_pkg::CH_NOISE) begin
          nshift_r <= nshift_step;
        end else begin
          tone_pos_r[tch] <= ~tone_pos_r[tch];
        end
      end

      // write bytes, only taken while idle
      if (wr_en && latch) begin
        last_field_r <= fld;
      end
      if (at_wr) begin
        atten_r[fld_t] <= ~byte_d[3:0];
      end
      if (fl_wr && (fld_t != psg_pkg::CH_NOISE)) begin
        freq_lo_r[fld_t] <= byte_d[3:0];
        period_r[fld_t]  <= per_lo;
        last_tone_r      <= fld_t;
      end
      if (hi_wr) begin
        if (last_tone_r == psg_pkg::CH_NOISE) begin
          period_r[0] <= {byte_d[5:0], 10'b0};
        end else begin
          freq_hi_r[hi_t] <= byte_d[5:0];
          period_r[hi_t]  <= per_hi;
          if ((hi_t == psg_pkg::CH_TONE1) && (nctl_r[1:0] == psg_pkg::RATE_TONE1)) begin
            period_r[0] <= per_hi;
          end
        end
      end
      if (nc_wr) begin
        nshift_r    <= psg_pkg::NSHIFT_SEED;
        nctl_r      <= byte_d[3:0];
        period_r[0] <= per_nc;
        // drop the noise count when the rate changes
        if (byte_d[1:0] != nctl_r[1:0]) begin
          cnt_r[0] <= '0;
        end
      end
    end
  end

  // accumulate the mix; clear it as a tick is taken
  always_ff @(posedge clk) begin
    if (tick) begin
      sum_r <= '0;
    end else if (ctrl.acc_en) begin
      sum_r <= res;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_sample_r <= sum_r[15:0];
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;

endmodule
`default_nettype wire

// ----- hw/rtl/psg_sat_add.sv -----
// Shared adder: counter decrement, counter reload and sample accumulation.
// Depends on psg_pkg (CNT_W, CNT_MIN).
`default_nettype none
module psg_sat_add (
  input  wire logic signed [psg_pkg::CNT_W-1:0] a,
  input  wire logic signed [psg_pkg::CNT_W-1:0] b,
  output logic signed [psg_pkg::CNT_W-1:0]      res
);
  logic signed [psg_pkg::CNT_W:0] full;

  always_comb begin
    full = {a[psg_pkg::CNT_W-1], a} + {b[psg_pkg::CNT_W-1], b};
    // clamp at the counter floor; the top end is never reached
    if (full < $signed({psg_pkg::CNT_MIN[psg_pkg::CNT_W-1], psg_pkg::CNT_MIN})) begin
      res = psg_pkg::CNT_MIN;
    end else begin
      res = full[psg_pkg::CNT_W-1:0];
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/psg_seq.sv -----
// Tick sequencer: walks the four channels through mix, decrement and reload.
// Depends on psg_pkg (state_t, op_t, ctrl_t, stat_t).
`default_nettype none
module psg_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire psg_pkg::stat_t stat,
  output psg_pkg::ctrl_t      ctrl
);
  psg_pkg::state_t state_r, state_nxt;
  logic [1:0]      ch_r, ch_nxt;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    ctrl          = '0;
    ctrl.ch       = ch_r;
    ctrl.op       = psg_pkg::OP_MIX;
    unique case (state_r)
      psg_pkg::ST_IDLE: begin
        ctrl.idle = 1'b1;
        if (start) begin
          state_nxt = psg_pkg::ST_MIX;
          ch_nxt    = psg_pkg::CH_NOISE;
        end
      end
      psg_pkg::ST_MIX: begin
        ctrl.acc_en = 1'b1;
        state_nxt   = psg_pkg::ST_DEC;
      end
      psg_pkg::ST_DEC: begin
        ctrl.op     = psg_pkg::OP_DEC;
        ctrl.cnt_wr = 1'b1;
        if (stat.res_neg && stat.per_nz) begin
          state_nxt = psg_pkg::ST_RELD;
        end else if (ch_r == psg_pkg::CH_LAST) begin
          state_nxt = psg_pkg::ST_OUT;
        end else begin
          state_nxt = psg_pkg::ST_MIX;
          ch_nxt    = ch_r + 2'd1;
        end
      end
      psg_pkg::ST_RELD: begin
        ctrl.op     = psg_pkg::OP_RELD;
        ctrl.cnt_wr = 1'b1;
        ctrl.step   = 1'b1;
        if (!stat.res_neg) begin
          if (ch_r == psg_pkg::CH_LAST) begin
            state_nxt = psg_pkg::ST_OUT;
          end else begin
            state_nxt = psg_pkg::ST_MIX;
            ch_nxt    = ch_r + 2'd1;
          end
        end
      end
      psg_pkg::ST_OUT: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_nxt     = psg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = psg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psg_pkg::ST_IDLE;
      ch_r    <= psg_pkg::CH_NOISE;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- dv/psg_three_tone_noise_generator_checker.sv -----
// Scoreboard for the sound generator: watches the word channels and the APB port,
// predicts each mixed sample and compares it with the block's output.
// Depends on psg_pkg, psg_in_if and psg_out_if.
`default_nettype none
module psg_three_tone_noise_generator_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  psg_in_if                                word_in,
  psg_out_if                               word_out,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [psg_pkg::PADDR_W-1:0] paddr,
  input  wire logic [psg_pkg::PDATA_W-1:0] pwdata,
  input  wire logic                        pready,
  output int                               mismatches,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import psg_pkg::*;

  localparam int CNT_FLOOR = -(1 << 18);
  localparam int AMP_LUT [16] = '{0, 76, 95, 120, 151, 191, 240, 302,
                                  380, 479, 602, 758, 955, 1202, 1514, 1905};

  logic [TDEC_W-1:0] tone_step;
  logic [NDEC_W-1:0] noise_step;
  logic              phase_pos [0:3];
  logic [15:0]       period [0:3];
  int                count [0:3];
  logic [3:0]        f_lo [0:3];
  logic [5:0]        f_hi [0:3];
  logic [3:0]        atten [0:3];
  logic [15:0]       lfsr;
  logic [3:0]        nctl;
  logic [1:0]        cur_tone;
  logic [2:0]        cur_field;
  logic signed [15:0] pending_samples [$];
  int                errs;

  function automatic logic [15:0] tone_period(input logic [1:0] t);
    return {f_hi[t], f_lo[t], 6'b0};
  endfunction

  function automatic int sat_dec(input int c, input int d);
    int r;
    r = c - d;
    return (r < CNT_FLOOR) ? CNT_FLOOR : r;
  endfunction

  function automatic void noise_ctl_write(input logic [7:0] v);
    lfsr = NSHIFT_SEED;
    if (v[1:0] != nctl[1:0]) count[CH_NOISE] = 0;
    nctl = v[3:0];
    if (v[1:0] == RATE_TONE1) period[CH_NOISE] = period[CH_TONE1];
    else period[CH_NOISE] = NOISE_BASE << v[1:0];
  endfunction

  function automatic void apply_write(input logic [7:0] d);
    logic [2:0] f;
    logic [1:0] ch;
    f = d[6:4];
    // both level and period fields map to channel ~f[2:1]
    ch = ~f[2:1];
    if (d[7]) begin
      cur_field = f;
      if (f == LF_NOISE_CTL) begin
        noise_ctl_write(d);
      end else if (f[0]) begin
        atten[ch] = 4'd15 - d[3:0];
      end else begin
        f_lo[ch] = d[3:0];
        period[ch] = tone_period(ch);
        cur_tone = ch;
      end
    end else if (cur_field == LF_NOISE_CTL) begin
      noise_ctl_write(d);
    end else if (cur_tone == CH_NOISE) begin
      // no tone latched yet: the byte lands on the noise period
      period[CH_NOISE] = {d[5:0], 10'b0};
    end else begin
      f_hi[cur_tone] = d[5:0];
      period[cur_tone] = tone_period(cur_tone);
      if (nctl[1:0] == RATE_TONE1 && cur_tone == CH_TONE1)
        period[CH_NOISE] = period[CH_TONE1];
    end
  endfunction

  // Mix from the current state, then advance every counter.
  function automatic logic signed [15:0] mix_and_advance();
    int acc;
    int g;
    int cnt;
    logic fb;
    acc = 0;
    for (int c = 1; c <= 3; c++) begin
      g = AMP_LUT[atten[c]];
      if (period[c] > FLAT_PERIOD && !phase_pos[c]) acc -= g;
      else acc += g;
    end
    if (!lfsr[0]) acc += 2 * AMP_LUT[atten[CH_NOISE]];
    for (int c = 1; c <= 3; c++) begin
      cnt = sat_dec(count[c], int'(tone_step));
      while (cnt < 0 && period[c] != 16'd0) begin
        cnt += int'(period[c]);
        phase_pos[c] = !phase_pos[c];
      end
      count[c] = cnt;
    end
    cnt = sat_dec(count[CH_NOISE], int'(noise_step));
    while (cnt < 0 && period[CH_NOISE] != 16'd0) begin
      cnt += 2 * int'(period[CH_NOISE]);
      fb = nctl[2] ? (lfsr[0] ^ lfsr[1]) : lfsr[0];
      lfsr = ({fb, 15'b0} | lfsr) >> 1;
    end
    count[CH_NOISE] = cnt;
    return acc[15:0];
  endfunction

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst_n) begin
      tone_step = TDEC_RST;
      noise_step = NDEC_RST;
      for (int c = 0; c <= 3; c++) begin
        phase_pos[c] = 1'b1;
        period[c] = PERIOD_RST;
        count[c] = 0;
        f_lo[c] = '0;
        f_hi[c] = '0;
        atten[c] = ATT_TONE_RST;
      end
      atten[CH_NOISE] = ATT_NOISE_RST;
      lfsr = NSHIFT_SEED;
      nctl = NCTL_RST;
      cur_tone = CH_NOISE;
      cur_field = '0;
      pending_samples.delete();
      errs = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TONE_DEC) tone_step = pwdata[TDEC_W-1:0];
        else noise_step = pwdata[NDEC_W-1:0];
      end
      // compare before predicting: a result always belongs to an older tick
      if (word_out.valid && word_out.ready) begin
        if (pending_samples.size() == 0) begin
          errs++;
          $display("%0t: unexpected sample word, expected none, got %0d",
                   $time, word_out.sample);
        end else begin
          want = pending_samples.pop_front();
          if (word_out.sample !== want) begin
            errs++;
            $display("%0t: sample mismatch, expected %0d, got %0d",
                     $time, want, word_out.sample);
          end
        end
      end
      if (word_in.valid && word_in.ready) begin
        if (word_in.kind == KIND_TICK) pending_samples.push_back(mix_and_advance());
        else apply_write(word_in.data);
      end
    end
    mismatches <= errs;
    pending <= pending_samples.size();
  end

endmodule
`default_nettype wire

// ----- dv/psg_three_tone_noise_generator_test.sv -----
// Top of the sound generator testbench: clock, reset, word and APB stimulus,
// output back-pressure, watchdog and verdict. Depends on psg_pkg, the two
// channel interfaces, the block and psg_three_tone_noise_generator_checker.
`default_nettype none
module psg_three_tone_noise_generator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import psg_pkg::*;

  // Latch field codes (bits 6..4 of a latch byte); noise control is LF_NOISE_CTL
  localparam logic [2:0] LF_T3_PER    = 3'd0;
  localparam logic [2:0] LF_T3_LVL    = 3'd1;
  localparam logic [2:0] LF_T2_PER    = 3'd2;
  localparam logic [2:0] LF_T2_LVL    = 3'd3;
  localparam logic [2:0] LF_T1_PER    = 3'd4;
  localparam logic [2:0] LF_T1_LVL    = 3'd5;
  localparam logic [2:0] LF_NOISE_LVL = 3'd7;

  // Longest stretch without any accepted word. A tick whose counters sat at
  // the floor must reload them back up one period at a time, so leave ample room.
  localparam int STALL_LIMIT = 100000;
  // Cycles to let a busy block settle before touching registers or ending
  localparam int SETTLE_CYCLES = 16;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  int                   mismatches;
  int                   pending;
  int                   idle_cycles;
  bit                   calm;

  psg_in_if  in_ch ();
  psg_out_if out_ch ();

  psg_three_tone_noise_generator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  psg_three_tone_noise_generator_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_in    (in_ch),
    .word_out   (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  // Gap length for either side: mostly none or short, now and then long.
  // During calm stretches both sides run flat out.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] latch(input logic [2:0] field, input logic [3:0] val);
    return {1'b1, field, val};
  endfunction

  // Offer one word and hold it until accepted. Valid stays high across
  // back-to-back words so it never gets two assignments in one step.
  task automatic send_word(input logic kind, input logic [7:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.data  <= data;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic put_byte(input logic [7:0] data);
    send_word(KIND_WRITE, data);
  endtask

  task automatic put_tick();
    send_word(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Drop valid, wait for every expected sample, then let the block go quiet.
  // The first edge lets the scoreboard count a tick accepted just now.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle until pready, then back to idle
  task automatic cfg_write(input logic idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Hand-picked opening: extremes of each field, every latch field, and the
  // corner cases the block has to get right.
  task automatic directed_words();
    // data byte before any tone latch: goes straight to the noise period
    put_byte(8'h3F);
    put_tick();
    put_byte(latch(LF_NOISE_LVL, 4'h0));   // noise at full volume
    put_tick();
    put_byte(8'h00);                      // noise period drops to zero
    put_tick();
    put_tick();
    // tone 1 at the longest period; noise follows it at rate code 3
    put_byte(latch(LF_T1_PER, 4'hF));
    put_byte(8'h3F);
    put_byte(latch(LF_T1_LVL, 4'h0));
    // tone 2 at the shortest nonzero period: flat level
    put_byte(latch(LF_T2_PER, 4'h1));
    put_byte(latch(LF_T2_LVL, 4'h0));
    // tone 3 with zero period and muted
    put_byte(latch(LF_T3_PER, 4'h0));
    put_byte(latch(LF_T3_LVL, 4'hF));
    put_tick();
    // white noise tracking tone 1, then white at the fastest fixed rate
    put_byte(latch(LF_NOISE_CTL, 4'h7));
    put_tick();
    put_tick();
    put_byte(latch(LF_NOISE_CTL, 4'h4));
    // data byte after a noise latch rewrites noise control
    put_byte(8'h03);
    put_tick();
    put_byte(latch(LF_T3_PER, 4'hA));
    put_byte(8'h2A);
    put_tick();
    put_tick();
    put_tick();
  endtask

  // Mostly well-formed latch/data pairs and ticks with random content,
  // with stray latch and data bytes mixed in.
  task automatic random_words(input int count);
    int r;
    int sent;
    logic [2:0] f;
    sent = 0;
    while (sent < count) begin
      if (sent % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        put_tick();
        sent++;
      end else if (r < 75) begin
        // period or noise control latch, then its data byte
        f = 3'($urandom_range(0, 3) * 2);
        put_byte(latch(f, 4'($urandom_range(0, 15))));
        put_byte({1'b0, 7'($urandom_range(0, 127))});
        sent += 2;
      end else if (r < 90) begin
        f = 3'($urandom_range(0, 3) * 2 + 1);
        put_byte(latch(f, 4'($urandom_range(0, 15))));
        sent++;
      end else begin
        put_byte(8'($urandom_range(0, 255)));
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  // Stimulus: directed opening on reset values, then random phases over
  // the decrement extremes (zero included) and random settings.
  initial begin
    logic [TDEC_W-1:0] tdec [5];
    logic [NDEC_W-1:0] ndec [5];
    int                words [5];
    tdec  = '{12'd4095, 12'd1, 12'd0, 12'($urandom_range(1, 4095)), TDEC_RST};
    ndec  = '{13'd8191, 13'd1, 13'd0, 13'($urandom_range(1, 8191)), 13'($urandom_range(1, 8191))};
    words = '{150, 150, 60, 150, 150};
    calm = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= KIND_WRITE;
    in_ch.data  <= 8'h00;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_words();
    for (int p = 0; p < 5; p++) begin
      drain();
      cfg_write(REG_TONE_DEC, PDATA_W'(tdec[p]));
      cfg_write(REG_NOISE_DEC, PDATA_W'(ndec[p]));
      random_words(words[p]);
    end
    drain();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result side back-pressure: random stalls, none while calm
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Watchdog: count cycles in which neither channel moves a word
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/psg_pkg.sv
hw/rtl/psg_in_if.sv
hw/rtl/psg_out_if.sv
hw/rtl/psg_sat_add.sv
hw/rtl/psg_seq.sv
hw/rtl/psg_three_tone_noise_generator.sv
dv/psg_three_tone_noise_generator_checker.sv
dv/psg_three_tone_noise_generator_test.sv
